/* design/power_zone_time_accumulator_macros.svh */
// ----------------------------------------------------------------------------
// Power zone time accumulator assertion macros
// Concurrent assertion wrappers shared by the design files.
// ----------------------------------------------------------------------------
`ifndef POWER_ZONE_TIME_ACCUMULATOR_MACROS_SVH
`define POWER_ZONE_TIME_ACCUMULATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Checks an implication or expression on every clock edge outside reset.
`define PZTA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that an expression is never true outside reset.
`define PZTA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define PZTA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PZTA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* design/pzta_pkg.sv */
// ----------------------------------------------------------------------------
// Power zone time accumulator package
// Widths, types and constants shared by the accumulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pzta_pkg;

	localparam int PowerW    = 12;
	localparam int TimeW     = 32;
	localparam int EnergyW   = 40;
	localparam int ZoneTimeW = 24;
	localparam int ZoneCount = 6;
	localparam int ZoneIdxW  = 3;
	localparam int CfgCount  = 5;
	localparam int CfgIdxW   = 3;
	localparam int ProdW     = PowerW + TimeW;
	localparam int SweepW    = $clog2(ZoneCount + 1);

	// kcal in Q8 is energy * 6400 / 22489. It is formed as the energy times a
	// rounded-up reciprocal scaled by 2^56; the rounding error stays below
	// 2^-16 for any 40-bit energy, well under the 1/22489 gap to the next
	// integer, so the floor is exact.
	localparam int KcalNum    = 6400;
	localparam int KcalDen    = 22489;
	localparam int KcalShift  = 56;
	localparam int KcalWideW  = 72;
	localparam int KcalRecipW = 55;
	// The energy is split into two 20-bit halves, the reciprocal into a 27-bit
	// upper and a 28-bit lower part, so each partial product fits 48 bits.
	localparam int KcalELoW   = 20;
	localparam int KcalMLoW   = 28;
	localparam int KcalPpW    = 48;
	localparam int KcalSumW   = 96;

	localparam logic [KcalWideW-1:0] KcalRecipWide =
		((KcalWideW'(1) << KcalShift) * KcalWideW'(KcalNum) + KcalWideW'(KcalDen) -
		KcalWideW'(1)) / KcalWideW'(KcalDen);
	localparam logic [KcalRecipW-1:0] KcalRecip = KcalRecipWide[KcalRecipW-1:0];

	typedef logic [PowerW-1:0]    power_t;
	typedef logic [TimeW-1:0]     time_t;
	typedef logic [EnergyW-1:0]   energy_t;
	typedef logic [ZoneTimeW-1:0] zone_time_t;
	typedef logic [ZoneIdxW-1:0]  zone_idx_t;
	typedef logic [CfgIdxW-1:0]   cfg_idx_t;
	typedef logic [ProdW-1:0]     prod_t;

	localparam energy_t    EnergyMax   = '1;
	localparam zone_time_t ZoneTimeMax = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACCUM,
		ST_START,
		ST_DIVIDE,
		ST_SWEEP
	} pzta_state_t;

	typedef struct packed {
		logic       we;
		zone_idx_t  addr;
		zone_time_t data;
	} ram_wr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

/* design/pzta_in_if.sv */
// ----------------------------------------------------------------------------
// Power sample channel
// Valid/ready channel carrying one power sample and its timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pzta_in_if;
	import pzta_pkg::*;

	logic   valid;
	logic   ready;
	power_t power_watts;
	time_t  timestamp_s;

	modport source (output valid, output power_watts, output timestamp_s, input ready);
	modport sink (input valid, input power_watts, input timestamp_s, output ready);

endinterface

/* design/pzta_out_if.sv */
// ----------------------------------------------------------------------------
// Accumulated result channel
// Valid/ready channel carrying the running totals after one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pzta_out_if;
	import pzta_pkg::*;

	logic       valid;
	logic       ready;
	logic       counted;
	zone_idx_t  zone_index;
	power_t     peak_power;
	energy_t    energy_joules;
	energy_t    kcal_q8;
	zone_time_t zone_time_0;
	zone_time_t zone_time_1;
	zone_time_t zone_time_2;
	zone_time_t zone_time_3;
	zone_time_t zone_time_4;
	zone_time_t zone_time_5;

	modport source (
		output valid, output counted, output zone_index, output peak_power,
		output energy_joules, output kcal_q8,
		output zone_time_0, output zone_time_1, output zone_time_2,
		output zone_time_3, output zone_time_4, output zone_time_5,
		input ready
	);
	modport sink (
		input valid, input counted, input zone_index, input peak_power,
		input energy_joules, input kcal_q8,
		input zone_time_0, input zone_time_1, input zone_time_2,
		input zone_time_3, input zone_time_4, input zone_time_5,
		output ready
	);

endinterface

/* design/pzta_zone_ram.sv */
// ----------------------------------------------------------------------------
// Zone timer memory
// Six-entry timer store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pzta_zone_ram (
	input  logic                clk,
	input  logic                arst_n,
	input  pzta_pkg::ram_wr_t   wr,
	input  pzta_pkg::zone_idx_t raddr,
	output pzta_pkg::zone_time_t rdata
);
	import pzta_pkg::*;

	zone_time_t             mem [ZoneCount];
	logic [ZoneCount-1:0]   valid_q;
	zone_time_t             rdata_q;

	// Entries that were never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we && wr.addr < ZoneIdxW'(ZoneCount)) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we && wr.addr < ZoneIdxW'(ZoneCount)) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (raddr < ZoneIdxW'(ZoneCount) && valid_q[raddr]) begin
			rdata_q <= mem[raddr];
		end else begin
			rdata_q <= '0;
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/pzta_kcal_div.sv */
// ----------------------------------------------------------------------------
// Calorie divider
// Division of energy * 6400 by 22489 through reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "power_zone_time_accumulator_macros.svh"

module pzta_kcal_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  pzta_pkg::energy_t       energy,
	output pzta_pkg::energy_t       quotient,
	output pzta_pkg::div_status_t   status
);
	import pzta_pkg::*;

	logic                             busy_q;
	logic                             done_q;
	logic [KcalPpW-1:0]               pp_hh_s1;
	logic [KcalPpW-1:0]               pp_hl_s1;
	logic [KcalPpW-1:0]               pp_lh_s1;
	logic [KcalPpW-1:0]               pp_ll_s1;
	energy_t                          quot_q;

	logic [KcalELoW-1:0]              e_lo;
	logic [EnergyW-KcalELoW-1:0]      e_hi;
	logic [KcalMLoW-1:0]              m_lo;
	logic [KcalRecipW-KcalMLoW-1:0]   m_hi;
	logic [KcalSumW-1:0]              prod_sum;

	assign e_lo = energy[KcalELoW-1:0];
	assign e_hi = energy[EnergyW-1:KcalELoW];
	assign m_lo = KcalRecip[KcalMLoW-1:0];
	assign m_hi = KcalRecip[KcalRecipW-1:KcalMLoW];

	// The four partial products are taken in the start cycle and summed in the
	// next one; the quotient is the sum shifted down by the reciprocal scale.
	assign prod_sum = (KcalSumW'(pp_hh_s1) << (KcalELoW + KcalMLoW)) +
		(KcalSumW'(pp_hl_s1) << KcalELoW) +
		(KcalSumW'(pp_lh_s1) << KcalMLoW) +
		KcalSumW'(pp_ll_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pp_hh_s1 <= KcalPpW'(e_hi) * KcalPpW'(m_hi);
			pp_hl_s1 <= KcalPpW'(e_hi) * KcalPpW'(m_lo);
			pp_lh_s1 <= KcalPpW'(e_lo) * KcalPpW'(m_hi);
			pp_ll_s1 <= KcalPpW'(e_lo) * KcalPpW'(m_lo);
		end
		if (busy_q) begin
			quot_q <= prod_sum[KcalSumW-1:KcalShift];
		end
	end

	assign quotient    = quot_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	`PZTA_ASSERT_NEVER(a_start_while_busy, clk, arst_n, start && busy_q, "divider restarted while busy")
	`PZTA_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q), "divider done without a run")
	`PZTA_ASSERT(a_quot_fits, clk, arst_n, done_q |-> !quot_q[EnergyW-1], "quotient overflow")

endmodule

/* design/power_zone_time_accumulator.sv */
// ----------------------------------------------------------------------------
// Power zone time accumulator
// Accumulates peak power, energy, calories and time per power zone.
// ----------------------------------------------------------------------------
// A result is offered once its accepted sample has gone through the zone timer
// read-modify-write and energy update, the reciprocal calorie multiply and a
// read-out sweep of the timers. No new sample is accepted until the result of the
// last one has been swept out, and the sweep waits while a result is not taken.
// Reset clears all totals, the thresholds and the first-sample flag at once.
`timescale 1ns / 1ps
`include "power_zone_time_accumulator_macros.svh"

module power_zone_time_accumulator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  pzta_pkg::cfg_idx_t cfg_index,
	input  pzta_pkg::power_t  cfg_data,
	pzta_in_if.sink           samples,
	pzta_out_if.source        results
);
	import pzta_pkg::*;

	// Control state.
	pzta_state_t   state_q;
	pzta_state_t   state_d;
	logic          seen_first_q;
	power_t        upper_q [CfgCount];
	time_t         prev_time_q;
	power_t        max_q;
	energy_t       energy_q;
	logic [SweepW-1:0] sweep_q;
	logic          out_valid_q;

	// Pipeline registers of the current sample.
	power_t        power_s1;
	time_t         step_s1;
	zone_idx_t     zone_s1;
	logic          counted_s1;
	prod_t         prod_s2;

	// Result register.
	logic          out_counted_q;
	zone_idx_t     out_zone_q;
	power_t        out_peak_q;
	energy_t       out_energy_q;
	energy_t       out_kcal_q;
	zone_time_t    out_zt_q [ZoneCount];

	// Combinational signals.
	logic          accept;
	logic          sweep_go;
	logic          sweep_last;
	zone_idx_t     zone_sel;
	time_t         step_now;
	zone_idx_t     ram_raddr;
	zone_time_t    ram_rdata;
	ram_wr_t       ram_wr;
	logic [TimeW:0] zone_sum;
	logic [ProdW:0] energy_sum;
	logic          div_start;
	energy_t       div_quot;
	div_status_t   div_st;

	// ------------------------------------------------------------------------
	// Zone selection: the first zone whose inclusive upper bound is not
	// exceeded wins, so thresholds that do not ascend still give a zone.
	// ------------------------------------------------------------------------
	always_comb begin
		zone_sel = ZoneIdxW'(CfgCount);
		for (int z = CfgCount - 1; z >= 0; z--) begin
			if (samples.power_watts <= upper_q[z]) begin
				zone_sel = ZoneIdxW'(z);
			end
		end
	end

	// A timestamp that goes backward gives a step of zero.
	assign step_now = (samples.timestamp_s >= prev_time_q) ?
		(samples.timestamp_s - prev_time_q) : '0;

	assign accept     = samples.valid && samples.ready;
	assign sweep_go   = (state_q == ST_SWEEP) && !out_valid_q;
	assign sweep_last = sweep_q == SweepW'(ZoneCount);

	// Saturating updates of the zone timer and the energy total.
	assign zone_sum   = (TimeW + 1)'(ram_rdata) + (TimeW + 1)'(step_s1);
	assign energy_sum = (ProdW + 1)'(energy_q) + (ProdW + 1)'(prod_s2);

	// ------------------------------------------------------------------------
	// Next state.
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_ACCUM;
			ST_ACCUM:  state_d = ST_START;
			ST_START:  state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (div_st.done) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sweep_go && sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// State outputs: the memory is read at the sample's zone on acceptance,
	// written back in the next cycle, and read entry by entry in the sweep.
	// ------------------------------------------------------------------------
	always_comb begin
		samples.ready = 1'b0;
		ram_raddr     = zone_sel;
		ram_wr.we     = 1'b0;
		ram_wr.addr   = zone_s1;
		ram_wr.data   = (zone_sum > (TimeW + 1)'(ZoneTimeMax)) ?
			ZoneTimeMax : zone_sum[ZoneTimeW-1:0];
		div_start     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
			end
			ST_READ: begin
				ram_wr.we = counted_s1;
			end
			ST_START: begin
				div_start = 1'b1;
			end
			ST_SWEEP: begin
				ram_raddr = sweep_q[ZoneIdxW-1:0];
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seen_first_q <= 1'b0;
			for (int i = 0; i < CfgCount; i++) begin
				upper_q[i] <= '0;
			end
			prev_time_q  <= '0;
			max_q        <= '0;
			energy_q     <= '0;
			sweep_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// Writes to an index beyond the threshold registers are dropped.
			if (cfg_we && cfg_index < CfgIdxW'(CfgCount)) begin
				upper_q[cfg_index] <= cfg_data;
			end

			if (accept) begin
				seen_first_q <= 1'b1;
				prev_time_q  <= samples.timestamp_s;
				if (seen_first_q && samples.power_watts > max_q) begin
					max_q <= samples.power_watts;
				end
			end

			if (state_q == ST_ACCUM && counted_s1) begin
				energy_q <= (energy_sum > (ProdW + 1)'(EnergyMax)) ?
					EnergyMax : energy_sum[EnergyW-1:0];
			end

			if (sweep_go) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end

			if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end else if (sweep_go && sweep_last) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			power_s1   <= samples.power_watts;
			step_s1    <= seen_first_q ? step_now : '0;
			zone_s1    <= seen_first_q ? zone_sel : '0;
			counted_s1 <= seen_first_q;
		end
		if (state_q == ST_READ) begin
			prod_s2 <= ProdW'(power_s1) * ProdW'(step_s1);
		end
	end

	// Read data of the sweep arrives in the cycle after its address.
	always_ff @(posedge clk) begin
		if (sweep_go) begin
			if (sweep_q != '0) begin
				out_zt_q[ZoneIdxW'(sweep_q - 1'b1)] <= ram_rdata;
			end
			if (sweep_last) begin
				out_counted_q <= counted_s1;
				out_zone_q    <= zone_s1;
				out_peak_q    <= max_q;
				out_energy_q  <= energy_q;
				out_kcal_q    <= div_quot;
			end
		end
	end

	pzta_zone_ram u_zone_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ram_wr),
		.raddr  (ram_raddr),
		.rdata  (ram_rdata)
	);

	pzta_kcal_div u_kcal_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.energy   (energy_q),
		.quotient (div_quot),
		.status   (div_st)
	);

	assign results.valid         = out_valid_q;
	assign results.counted       = out_counted_q;
	assign results.zone_index    = out_zone_q;
	assign results.peak_power    = out_peak_q;
	assign results.energy_joules = out_energy_q;
	assign results.kcal_q8       = out_kcal_q;
	assign results.zone_time_0   = out_zt_q[0];
	assign results.zone_time_1   = out_zt_q[1];
	assign results.zone_time_2   = out_zt_q[2];
	assign results.zone_time_3   = out_zt_q[3];
	assign results.zone_time_4   = out_zt_q[4];
	assign results.zone_time_5   = out_zt_q[5];

	`PZTA_ASSERT_NEVER(a_accept_div_busy, clk, arst_n, accept && div_st.busy, "sample taken while dividing")
	`PZTA_ASSERT(a_zone_range, clk, arst_n, (state_q == ST_READ) |-> (zone_s1 < ZoneIdxW'(ZoneCount)), "zone out of range")
	`PZTA_ASSERT(a_sweep_free, clk, arst_n, (sweep_q != '0) |-> !out_valid_q, "sweep overwrote a pending result")
	`PZTA_ASSERT(a_uncounted_zone, clk, arst_n, (out_valid_q && !out_counted_q) |-> (out_zone_q == '0), "zone set on first sample")

endmodule
